>>> src/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Clocked assertion helpers, reset-qualified on the local i_clk / i_rst_n.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

>>> src/hmc_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// hmc_pkg
// Shared types, mode codes, duty levels and register map of the humidity
// mode controller.
// ----------------------------------------------------------------------------
package hmc_pkg;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;

    localparam logic [1:0] MODE_IDLE       = 2'd0;
    localparam logic [1:0] MODE_HUMIDIFY   = 2'd1;
    localparam logic [1:0] MODE_DEHUMIDIFY = 2'd2;
    localparam logic [1:0] MODE_EMERGENCY  = 2'd3;

    localparam logic [9:0] DUTY_OFF     = 10'd0;
    localparam logic [9:0] DUTY_FULL    = 10'd1023;
    localparam logic [9:0] DUTY_HIGH    = 10'd819;
    localparam logic [9:0] DUTY_SEVENTY = 10'd716;
    localparam logic [9:0] DUTY_HALF    = 10'd512;
    localparam logic [9:0] DUTY_LOW     = 10'd205;

    localparam logic [CFG_IDX_W-1:0] REG_TARGET_HUM   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_HYSTERESIS   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_ERROR_LIMIT  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_WATER_EMERG  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_WATER_RESET  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_FAN_HOT      = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_BOOST_LIMIT  = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_RUNTIME  = 3'd7;

    localparam logic [9:0]         RST_TARGET_HUM  = 10'd600;
    localparam logic [7:0]         RST_HYSTERESIS  = 8'd20;
    localparam logic [15:0]        RST_ERROR_LIMIT = 16'd5;
    localparam logic signed [11:0] RST_WATER_EMERG = 12'sd700;
    localparam logic signed [11:0] RST_WATER_RESET = 12'sd550;
    localparam logic signed [11:0] RST_FAN_HOT     = 12'sd450;
    localparam logic signed [11:0] RST_BOOST_LIMIT = 12'sd600;
    localparam logic [31:0]        RST_MAX_RUNTIME = 32'd7200000;

    typedef struct packed {
        logic [9:0]         humidity;
        logic               air_valid;
        logic signed [11:0] water_temp;
        logic               water_valid;
        logic [15:0]        sensor_err_cnt;
        logic               reset_request;
        logic [31:0]        now_ms;
    } t_in_word;

    typedef struct packed {
        logic [1:0] mode;
        logic [9:0] heater_duty;
        logic [9:0] blow_fan_duty;
        logic [9:0] cabinet_fan_duty;
        logic [9:0] circulation_duty;
        logic       pump_on;
    } t_out_word;

endpackage
`default_nettype wire

>>> src/hmc_in_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// hmc_in_if
// Sensor snapshot channel: valid/ready with the snapshot fields.
// ----------------------------------------------------------------------------
interface hmc_in_if;
    logic               valid;
    logic               ready;
    logic [9:0]         humidity;
    logic               air_valid;
    logic signed [11:0] water_temp;
    logic               water_valid;
    logic [15:0]        sensor_err_cnt;
    logic               reset_request;
    logic [31:0]        now_ms;

    modport source (output valid, humidity, air_valid, water_temp, water_valid,
                    sensor_err_cnt, reset_request, now_ms, input ready);
    modport sink   (input valid, humidity, air_valid, water_temp, water_valid,
                    sensor_err_cnt, reset_request, now_ms, output ready);
endinterface
`default_nettype wire

>>> src/hmc_out_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// hmc_out_if
// Result channel: valid/ready with mode, actuator duties and pump flag.
// ----------------------------------------------------------------------------
interface hmc_out_if;
    logic       valid;
    logic       ready;
    logic [1:0] mode;
    logic [9:0] heater_duty;
    logic [9:0] blow_fan_duty;
    logic [9:0] cabinet_fan_duty;
    logic [9:0] circulation_duty;
    logic       pump_on;

    modport source (output valid, mode, heater_duty, blow_fan_duty, cabinet_fan_duty,
                    circulation_duty, pump_on, input ready);
    modport sink   (input valid, mode, heater_duty, blow_fan_duty, cabinet_fan_duty,
                    circulation_duty, pump_on, output ready);
endinterface
`default_nettype wire

>>> src/humidity_mode_controller.sv
// Pipeline: an accepted input word is held in the input register, and its result
//   word is written to the result register when the input register advances.
// Throughput: 1 word per cycle while the result side is ready; the mode register
//   updates once per word as it moves from the input register to the result register.
// Reset (synchronous, i_rst_n low): mode idle, run start 0, config registers
//   to defaults, both pipeline stages empty.
`default_nettype none
`include "assert_macros.svh"
// ----------------------------------------------------------------------------
// humidity_mode_controller
// Mode controller for a humidifier: fault/emergency handling, hysteresis run
// start, run timeout and actuator duty decode.
// ----------------------------------------------------------------------------
module humidity_mode_controller (
    input  wire                           i_clk,
    input  wire                           i_rst_n,
    input  wire                           i_cfg_we,
    input  wire [hmc_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  wire [hmc_pkg::CFG_DATA_W-1:0] i_cfg_data,
    hmc_in_if.sink                        i_in,
    hmc_out_if.source                     o_out
);
    import hmc_pkg::*;

    // configuration
    logic [9:0]         r_target_hum;
    logic [7:0]         r_hysteresis;
    logic [15:0]        r_error_limit;
    logic signed [11:0] r_water_emerg;
    logic signed [11:0] r_water_reset;
    logic signed [11:0] r_fan_hot;
    logic signed [11:0] r_boost_limit;
    logic [31:0]        r_max_runtime;

    // pipeline and state
    logic       r_s1_vld;
    t_in_word   r_s1;
    logic       r_out_vld;
    t_out_word  r_out;
    logic [1:0] r_mode;
    logic [31:0] r_start;

    logic       s1_adv;
    logic       in_acc;
    t_in_word   in_word;
    logic [1:0] n_mode;
    logic [31:0] n_start;
    t_out_word  n_out;

    logic signed [11:0] hum_s;
    logic signed [11:0] band_lo;
    logic signed [11:0] band_hi;
    logic signed [11:0] tgt_s;
    logic [31:0]        elapsed;
    logic               timeout;
    logic               fault;
    logic [1:0]         chk_mode;

    assign s1_adv   = r_s1_vld && (!r_out_vld || o_out.ready);
    assign i_in.ready = !r_s1_vld || s1_adv;
    assign in_acc   = i_in.valid && i_in.ready;

    assign in_word.humidity       = i_in.humidity;
    assign in_word.air_valid      = i_in.air_valid;
    assign in_word.water_temp     = i_in.water_temp;
    assign in_word.water_valid    = i_in.water_valid;
    assign in_word.sensor_err_cnt = i_in.sensor_err_cnt;
    assign in_word.reset_request  = i_in.reset_request;
    assign in_word.now_ms         = i_in.now_ms;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_target_hum  <= RST_TARGET_HUM;
            r_hysteresis  <= RST_HYSTERESIS;
            r_error_limit <= RST_ERROR_LIMIT;
            r_water_emerg <= RST_WATER_EMERG;
            r_water_reset <= RST_WATER_RESET;
            r_fan_hot     <= RST_FAN_HOT;
            r_boost_limit <= RST_BOOST_LIMIT;
            r_max_runtime <= RST_MAX_RUNTIME;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_TARGET_HUM:  r_target_hum  <= i_cfg_data[9:0];
                REG_HYSTERESIS:  r_hysteresis  <= i_cfg_data[7:0];
                REG_ERROR_LIMIT: r_error_limit <= i_cfg_data[15:0];
                REG_WATER_EMERG: r_water_emerg <= i_cfg_data[11:0];
                REG_WATER_RESET: r_water_reset <= i_cfg_data[11:0];
                REG_FAN_HOT:     r_fan_hot     <= i_cfg_data[11:0];
                REG_BOOST_LIMIT: r_boost_limit <= i_cfg_data[11:0];
                REG_MAX_RUNTIME: r_max_runtime <= i_cfg_data[31:0];
                default: begin
                end
            endcase
        end
    end

    // band edges in 12-bit signed; target + hysteresis tops out at 1278
    assign hum_s   = signed'({2'b00, r_s1.humidity});
    assign tgt_s   = signed'({2'b00, r_target_hum});
    assign band_lo = tgt_s - signed'({4'b0000, r_hysteresis});
    assign band_hi = tgt_s + signed'({4'b0000, r_hysteresis});
    assign elapsed = r_s1.now_ms - r_start;
    assign timeout = elapsed > r_max_runtime;
    assign fault   = (r_s1.sensor_err_cnt > r_error_limit)
                   || (r_s1.water_valid && (r_s1.water_temp > r_water_emerg));

    always_comb begin
        chk_mode = (r_mode != MODE_EMERGENCY && fault) ? MODE_EMERGENCY : r_mode;
        n_mode   = chk_mode;
        n_start  = r_start;
        case (chk_mode)
            MODE_EMERGENCY: begin
                if (r_s1.reset_request && r_s1.water_valid
                    && (r_s1.water_temp < r_water_reset))
                    n_mode = MODE_IDLE;
            end
            MODE_IDLE: begin
                n_start = '0;
                if (r_s1.air_valid) begin
                    if (hum_s < band_lo) begin
                        n_mode  = MODE_HUMIDIFY;
                        n_start = r_s1.now_ms;
                    end else if (hum_s > band_hi) begin
                        n_mode  = MODE_DEHUMIDIFY;
                        n_start = r_s1.now_ms;
                    end
                end
            end
            MODE_HUMIDIFY: begin
                if ((r_s1.humidity >= r_target_hum) || timeout)
                    n_mode = MODE_IDLE;
            end
            default: begin
                if ((r_s1.humidity <= r_target_hum) || timeout)
                    n_mode = MODE_IDLE;
            end
        endcase
    end

    // actuator decode from the new mode
    always_comb begin
        n_out.mode             = n_mode;
        n_out.heater_duty      = DUTY_OFF;
        n_out.blow_fan_duty    = DUTY_OFF;
        n_out.cabinet_fan_duty = DUTY_OFF;
        n_out.circulation_duty = DUTY_OFF;
        n_out.pump_on          = 1'b0;
        case (n_mode)
            MODE_IDLE: begin
                n_out.circulation_duty = DUTY_SEVENTY;
                n_out.cabinet_fan_duty = (r_s1.water_valid && (r_s1.water_temp > r_fan_hot))
                                       ? DUTY_FULL : DUTY_SEVENTY;
            end
            MODE_HUMIDIFY: begin
                n_out.pump_on          = 1'b1;
                n_out.circulation_duty = DUTY_HALF;
                if (!r_s1.water_valid) begin
                    n_out.cabinet_fan_duty = DUTY_SEVENTY;
                end else if (r_s1.water_temp < r_boost_limit) begin
                    n_out.heater_duty = DUTY_FULL;
                end else begin
                    n_out.heater_duty      = DUTY_SEVENTY;
                    n_out.cabinet_fan_duty = DUTY_LOW;
                end
            end
            MODE_DEHUMIDIFY: begin
                n_out.circulation_duty = DUTY_HIGH;
                n_out.heater_duty      = DUTY_SEVENTY;
                n_out.blow_fan_duty    = DUTY_FULL;
                n_out.cabinet_fan_duty = DUTY_FULL;
            end
            default: begin
                n_out.cabinet_fan_duty = DUTY_FULL;
                n_out.blow_fan_duty    = DUTY_FULL;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld  <= 1'b0;
            r_out_vld <= 1'b0;
            r_mode    <= MODE_IDLE;
            r_start   <= '0;
        end else begin
            if (in_acc)
                r_s1_vld <= 1'b1;
            else if (s1_adv)
                r_s1_vld <= 1'b0;
            if (s1_adv) begin
                r_out_vld <= 1'b1;
                r_mode    <= n_mode;
                r_start   <= n_start;
            end else if (o_out.ready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc)
            r_s1 <= in_word;
        if (s1_adv)
            r_out <= n_out;
    end

    assign o_out.valid            = r_out_vld;
    assign o_out.mode             = r_out.mode;
    assign o_out.heater_duty      = r_out.heater_duty;
    assign o_out.blow_fan_duty    = r_out.blow_fan_duty;
    assign o_out.cabinet_fan_duty = r_out.cabinet_fan_duty;
    assign o_out.circulation_duty = r_out.circulation_duty;
    assign o_out.pump_on          = r_out.pump_on;

    // result word carries the mode that was just committed to state
    `ASSERT_NEXT(a_out_mode_state, s1_adv, r_out.mode == r_mode, "result mode != state")
    // emergency is only left on a reset request
    `ASSERT_IMPL(a_emerg_exit, s1_adv && r_mode == MODE_EMERGENCY && n_mode != MODE_EMERGENCY,
                 r_s1.reset_request, "emergency left without reset request")
    // a run started from idle latches the snapshot time
    `ASSERT_NEXT(a_run_start, s1_adv && r_mode == MODE_IDLE && n_mode == MODE_HUMIDIFY,
                 r_start == $past(r_s1.now_ms), "run start time not latched")
    // pump runs exactly in humidify
    `ASSERT_IMPL(a_pump_mode, r_out_vld, r_out.pump_on == (r_out.mode == MODE_HUMIDIFY),
                 "pump flag does not match mode")

endmodule
`default_nettype wire

>>> verif/hmc_actuation_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// hmc_actuation_checker
// Watches the config port and both channels of the humidity mode controller,
// predicts the mode and actuator word for every accepted snapshot and checks
// each result word against the oldest prediction.
// ----------------------------------------------------------------------------
module hmc_actuation_checker
    import hmc_pkg::*;
(
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  wire                  i_cfg_we,
    input  wire [CFG_IDX_W-1:0]  i_cfg_idx,
    input  wire [CFG_DATA_W-1:0] i_cfg_data,
    hmc_in_if                    i_in,
    hmc_out_if                   i_out,
    output int                   o_fail_total,
    output int                   o_outstanding
);

    // shadow config
    logic [9:0]         target_q;
    logic [7:0]         hyst_q;
    logic [15:0]        err_lim_q;
    logic signed [11:0] emerg_q;
    logic signed [11:0] reset_q;
    logic signed [11:0] fan_hot_q;
    logic signed [11:0] boost_q;
    logic [31:0]        max_run_q;

    // shadow state
    logic [1:0]  mode_q;
    logic [31:0] run_start_q;

    t_out_word   pending_actuation[$];
    t_in_word    snap_w;
    t_out_word   pred_w;
    t_out_word   want_w;
    int          error_total = 0;

    assign o_fail_total = error_total;

    task automatic report_mismatch(input string what);
        error_total++;
        $display("%0t hmc_check: %s", $time, what);
    endtask

    task automatic check_field(input string name, input logic [9:0] got,
                               input logic [9:0] want);
        if (got !== want)
            report_mismatch($sformatf("%s got %0d want %0d", name, got, want));
    endtask

    task automatic step_controller(input t_in_word w, output t_out_word r);
        logic [1:0]  m;
        int          hum;
        int          band_lo;
        int          band_hi;
        logic [31:0] elapsed;
        logic        water_good;
        m          = mode_q;
        hum        = int'(w.humidity);
        // band edges are signed, so a low edge under zero never starts a run
        band_lo    = int'(target_q) - int'(hyst_q);
        band_hi    = int'(target_q) + int'(hyst_q);
        elapsed    = w.now_ms - run_start_q;
        water_good = w.water_valid;

        if (m != MODE_EMERGENCY) begin
            if (w.sensor_err_cnt > err_lim_q ||
                (water_good && $signed(w.water_temp) > emerg_q))
                m = MODE_EMERGENCY;
        end

        // fault check first, so a reset can leave emergency in the same word
        if (m == MODE_EMERGENCY) begin
            if (w.reset_request && water_good && $signed(w.water_temp) < reset_q)
                m = MODE_IDLE;
        end else if (m == MODE_IDLE) begin
            run_start_q = '0;
            if (w.air_valid) begin
                if (hum < band_lo) begin
                    m           = MODE_HUMIDIFY;
                    run_start_q = w.now_ms;
                end else if (hum > band_hi) begin
                    m           = MODE_DEHUMIDIFY;
                    run_start_q = w.now_ms;
                end
            end
        end else if (m == MODE_HUMIDIFY) begin
            if (hum >= int'(target_q) || elapsed > max_run_q)
                m = MODE_IDLE;
        end else begin
            if (hum <= int'(target_q) || elapsed > max_run_q)
                m = MODE_IDLE;
        end
        mode_q = m;

        r      = '0;
        r.mode = m;
        case (m)
            MODE_IDLE: begin
                r.circulation_duty = DUTY_SEVENTY;
                r.cabinet_fan_duty = (water_good && $signed(w.water_temp) > fan_hot_q) ?
                                     DUTY_FULL : DUTY_SEVENTY;
            end
            MODE_HUMIDIFY: begin
                r.pump_on          = 1'b1;
                r.circulation_duty = DUTY_HALF;
                if (!water_good) begin
                    r.heater_duty      = DUTY_OFF;
                    r.cabinet_fan_duty = DUTY_SEVENTY;
                end else if ($signed(w.water_temp) < boost_q) begin
                    r.heater_duty      = DUTY_FULL;
                    r.cabinet_fan_duty = DUTY_OFF;
                end else begin
                    r.heater_duty      = DUTY_SEVENTY;
                    r.cabinet_fan_duty = DUTY_LOW;
                end
            end
            MODE_DEHUMIDIFY: begin
                r.circulation_duty = DUTY_HIGH;
                r.heater_duty      = DUTY_SEVENTY;
                r.blow_fan_duty    = DUTY_FULL;
                r.cabinet_fan_duty = DUTY_FULL;
            end
            default: begin
                r.cabinet_fan_duty = DUTY_FULL;
                r.blow_fan_duty    = DUTY_FULL;
            end
        endcase
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            target_q    <= RST_TARGET_HUM;
            hyst_q      <= RST_HYSTERESIS;
            err_lim_q   <= RST_ERROR_LIMIT;
            emerg_q     <= RST_WATER_EMERG;
            reset_q     <= RST_WATER_RESET;
            fan_hot_q   <= RST_FAN_HOT;
            boost_q     <= RST_BOOST_LIMIT;
            max_run_q   <= RST_MAX_RUNTIME;
            mode_q      = MODE_IDLE;
            run_start_q = '0;
            pending_actuation.delete();
            o_outstanding <= 0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    REG_TARGET_HUM:  target_q  <= i_cfg_data[9:0];
                    REG_HYSTERESIS:  hyst_q    <= i_cfg_data[7:0];
                    REG_ERROR_LIMIT: err_lim_q <= i_cfg_data[15:0];
                    REG_WATER_EMERG: emerg_q   <= i_cfg_data[11:0];
                    REG_WATER_RESET: reset_q   <= i_cfg_data[11:0];
                    REG_FAN_HOT:     fan_hot_q <= i_cfg_data[11:0];
                    REG_BOOST_LIMIT: boost_q   <= i_cfg_data[11:0];
                    REG_MAX_RUNTIME: max_run_q <= i_cfg_data;
                    default: ;
                endcase
            end
            if (i_in.valid && i_in.ready) begin
                snap_w.humidity       = i_in.humidity;
                snap_w.air_valid      = i_in.air_valid;
                snap_w.water_temp     = i_in.water_temp;
                snap_w.water_valid    = i_in.water_valid;
                snap_w.sensor_err_cnt = i_in.sensor_err_cnt;
                snap_w.reset_request  = i_in.reset_request;
                snap_w.now_ms         = i_in.now_ms;
                step_controller(snap_w, pred_w);
                pending_actuation.push_back(pred_w);
            end
            if (i_out.valid && i_out.ready) begin
                if (pending_actuation.size() == 0) begin
                    report_mismatch("result word with no snapshot pending");
                end else begin
                    want_w = pending_actuation.pop_front();
                    check_field("mode", 10'(i_out.mode), 10'(want_w.mode));
                    check_field("heater", i_out.heater_duty, want_w.heater_duty);
                    check_field("blower", i_out.blow_fan_duty, want_w.blow_fan_duty);
                    check_field("case_fan", i_out.cabinet_fan_duty,
                                want_w.cabinet_fan_duty);
                    check_field("circulation", i_out.circulation_duty,
                                want_w.circulation_duty);
                    check_field("pump", 10'(i_out.pump_on), 10'(want_w.pump_on));
                end
            end
            o_outstanding <= pending_actuation.size();
        end
    end

endmodule

>>> verif/humidity_mode_controller_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// humidity_mode_controller_test
// Drives snapshots and config writes into the mode controller with random
// backpressure on both sides; the checker beside the block predicts and
// compares every result word.
// ----------------------------------------------------------------------------
module humidity_mode_controller_test;
    import hmc_pkg::*;

    localparam int STALL_LIMIT  = 2000;
    localparam int SEGMENTS     = 9;
    localparam int SEG_WORDS    = 211;
    localparam int DRAIN_CYCLES = 4;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n;
    logic                  i_cfg_we;
    logic [CFG_IDX_W-1:0]  i_cfg_idx;
    logic [CFG_DATA_W-1:0] i_cfg_data;

    int          fail_count;
    int          outstanding;
    int          tx_idle_pct;
    int          rx_idle_pct;

    // config as last programmed, used to bias the stimulus
    int          cur_target;
    int          cur_hyst;
    int          cur_err_lim;
    int          cur_emerg;
    int          cur_reset;
    int          cur_fan;
    int          cur_boost;
    logic [31:0] cur_max;
    logic [31:0] now_cursor;

    hmc_in_if  in_if ();
    hmc_out_if out_if ();

    humidity_mode_controller u_top (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_in       (in_if),
        .o_out      (out_if)
    );

    hmc_actuation_checker u_chk (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_data    (i_cfg_data),
        .i_in          (in_if),
        .i_out         (out_if),
        .o_fail_total  (fail_count),
        .o_outstanding (outstanding)
    );

    always #5 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        out_if.ready <= ($urandom_range(99) >= rx_idle_pct);
    end

    initial begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < STALL_LIMIT) begin
            @(posedge i_clk);
            if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("humidity_mode_controller_test: done, errors");
        $finish;
    end

    function automatic t_in_word snap(input int hum, input bit air, input int wt,
                                      input bit wv, input int errs, input bit rr,
                                      input logic [31:0] now);
        t_in_word w;
        w.humidity       = 10'(hum);
        w.air_valid      = air;
        w.water_temp     = 12'(wt);
        w.water_valid    = wv;
        w.sensor_err_cnt = 16'(errs);
        w.reset_request  = rr;
        w.now_ms         = now;
        return w;
    endfunction

    task automatic send_snapshot(input t_in_word w);
        while ($urandom_range(99) < tx_idle_pct) begin
            in_if.valid <= 1'b0;
            @(posedge i_clk);
        end
        in_if.valid          <= 1'b1;
        in_if.humidity       <= w.humidity;
        in_if.air_valid      <= w.air_valid;
        in_if.water_temp     <= w.water_temp;
        in_if.water_valid    <= w.water_valid;
        in_if.sensor_err_cnt <= w.sensor_err_cnt;
        in_if.reset_request  <= w.reset_request;
        in_if.now_ms         <= w.now_ms;
        @(posedge i_clk);
        while (!in_if.ready) @(posedge i_clk);
    endtask

    // hold the sender until every predicted word has come back
    task automatic drain_results();
        in_if.valid <= 1'b0;
        @(posedge i_clk);
        while (outstanding != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
    endtask

    task automatic program_config();
        write_reg(REG_TARGET_HUM, 32'(cur_target));
        write_reg(REG_HYSTERESIS, 32'(cur_hyst));
        write_reg(REG_ERROR_LIMIT, 32'(cur_err_lim));
        write_reg(REG_WATER_EMERG, 32'(cur_emerg));
        write_reg(REG_WATER_RESET, 32'(cur_reset));
        write_reg(REG_FAN_HOT, 32'(cur_fan));
        write_reg(REG_BOOST_LIMIT, 32'(cur_boost));
        write_reg(REG_MAX_RUNTIME, cur_max);
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic set_defaults();
        cur_target  = 600;
        cur_hyst    = 20;
        cur_err_lim = 5;
        cur_emerg   = 700;
        cur_reset   = 550;
        cur_fan     = 450;
        cur_boost   = 600;
        cur_max     = 32'd7200000;
    endtask

    task automatic pick_settings(input int seg);
        case (seg)
            0: begin
                set_defaults();
                cur_max = 32'd200;
            end
            1: begin
                cur_target  = 0;
                cur_hyst    = 0;
                cur_err_lim = 0;
                cur_emerg   = -400;
                cur_reset   = -400;
                cur_fan     = -400;
                cur_boost   = -400;
                cur_max     = 32'd0;
            end
            2: begin
                cur_target  = 1000;
                cur_hyst    = 200;
                cur_err_lim = 65535;
                cur_emerg   = 1250;
                cur_reset   = 1250;
                cur_fan     = 1250;
                cur_boost   = 1250;
                cur_max     = 32'hFFFF_FFFF;
            end
            default: begin
                cur_target  = int'($urandom_range(0, 1000));
                cur_hyst    = int'($urandom_range(0, 200));
                cur_err_lim = ($urandom_range(3) == 0) ? 65535 : int'($urandom_range(0, 20));
                cur_emerg   = int'($urandom_range(0, 1650)) - 400;
                cur_reset   = int'($urandom_range(0, 1650)) - 400;
                cur_fan     = int'($urandom_range(0, 1650)) - 400;
                cur_boost   = int'($urandom_range(0, 1650)) - 400;
                case ($urandom_range(3))
                    0:       cur_max = $urandom_range(0, 40);
                    1:       cur_max = $urandom_range(41, 400);
                    2:       cur_max = 32'd7200000;
                    default: cur_max = 32'hFFFF_FFFF;
                endcase
            end
        endcase
    endtask

    task automatic next_snapshot(output t_in_word w);
        int h;
        int wt;
        int sel;
        sel = int'($urandom_range(99));
        if (sel < 70) begin
            h = cur_target + int'($urandom_range(0, 2 * cur_hyst + 40)) - (cur_hyst + 20);
            if (h < 0) h = 0;
            if (h > 1023) h = 1023;
        end else if (sel < 90) begin
            h = int'($urandom_range(0, 1000));
        end else begin
            h = int'($urandom_range(0, 1023));
        end
        w.humidity  = 10'(h);
        w.air_valid = ($urandom_range(99) < 85);

        // water mostly near one of the four thresholds
        sel = int'($urandom_range(99));
        if (sel < 60) begin
            case ($urandom_range(3))
                0:       wt = cur_emerg;
                1:       wt = cur_reset;
                2:       wt = cur_fan;
                default: wt = cur_boost;
            endcase
            wt = wt + int'($urandom_range(0, 10)) - 5;
        end else if (sel < 90) begin
            wt = int'($urandom_range(0, 1650)) - 400;
        end else begin
            wt = int'($urandom_range(0, 4095));
        end
        w.water_temp  = 12'(wt);
        w.water_valid = ($urandom_range(99) < 85);

        sel = int'($urandom_range(99));
        if (sel < 90)
            w.sensor_err_cnt = 16'($urandom_range(0, cur_err_lim));
        else if (sel < 95)
            w.sensor_err_cnt = (cur_err_lim == 65535) ? 16'hFFFF : 16'(cur_err_lim + 1);
        else
            w.sensor_err_cnt = 16'($urandom());
        w.reset_request = ($urandom_range(99) < 20);

        sel = int'($urandom_range(99));
        if (sel < 85)
            now_cursor = now_cursor + $urandom_range(0, 64);
        else if (sel < 95)
            now_cursor = now_cursor + cur_max + $urandom_range(0, 2) - 32'd1;
        else
            now_cursor = $urandom();
        w.now_ms = now_cursor;
    endtask

    initial begin : stimulus
        t_in_word w;
        i_rst_n              = 1'b0;
        i_cfg_we             = 1'b0;
        i_cfg_idx            = '0;
        i_cfg_data           = '0;
        in_if.valid          = 1'b0;
        in_if.humidity       = '0;
        in_if.air_valid      = 1'b0;
        in_if.water_temp     = '0;
        in_if.water_valid    = 1'b0;
        in_if.sensor_err_cnt = '0;
        in_if.reset_request  = 1'b0;
        in_if.now_ms         = '0;
        tx_idle_pct          = 29;
        rx_idle_pct          = 47;
        now_cursor           = '0;
        set_defaults();

        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed pass on reset config
        send_snapshot(snap(600, 1, 300, 1, 0, 0, 32'd0));
        send_snapshot(snap(500, 1, 300, 1, 0, 0, 32'd1000));
        send_snapshot(snap(500, 1, 650, 1, 0, 0, 32'd1100));
        // run ignores air_valid; invalid water turns the heater off
        send_snapshot(snap(550, 0, 900, 0, 0, 0, 32'd1200));
        send_snapshot(snap(600, 0, 300, 1, 0, 0, 32'd1300));
        send_snapshot(snap(590, 1, 500, 1, 0, 0, 32'd1400));
        send_snapshot(snap(590, 1, 500, 0, 0, 0, 32'd1500));
        send_snapshot(snap(700, 1, 300, 1, 0, 0, 32'd2000));
        send_snapshot(snap(650, 1, 300, 1, 0, 0, 32'd7202000));
        send_snapshot(snap(650, 1, 300, 1, 0, 0, 32'd7202001));
        // run starting just before the ms clock wraps
        send_snapshot(snap(1000, 1, 300, 1, 0, 0, 32'hFFFF_F000));
        send_snapshot(snap(1000, 1, 300, 1, 0, 0, 32'h0000_1000));
        send_snapshot(snap(1000, 1, 300, 1, 6, 0, 32'h0000_2000));
        // leave emergency on a reset request, then enter it again and leave it
        send_snapshot(snap(600, 1, 500, 1, 65535, 1, 32'd10));
        send_snapshot(snap(600, 1, 701, 1, 0, 0, 32'd20));
        send_snapshot(snap(600, 1, 0, 0, 0, 1, 32'd30));
        send_snapshot(snap(600, 1, 550, 1, 0, 1, 32'd40));
        send_snapshot(snap(600, 1, 0, 1, 0, 0, 32'd50));
        send_snapshot(snap(600, 1, 549, 1, 0, 1, 32'd60));
        send_snapshot(snap(600, 1, 2047, 0, 0, 0, 32'd70));
        send_snapshot(snap(0, 0, -2048, 0, 0, 0, 32'd80));
        send_snapshot(snap(1023, 1, -400, 1, 0, 0, 32'd90));
        send_snapshot(snap(0, 1, 1250, 0, 0, 0, 32'd100));
        drain_results();

        // low band edge below zero must not start humidify
        cur_target = 10;
        cur_hyst   = 200;
        program_config();
        send_snapshot(snap(0, 1, 300, 1, 0, 0, 32'd200));
        send_snapshot(snap(211, 1, 300, 1, 0, 0, 32'd300));
        drain_results();

        for (int seg = 0; seg < SEGMENTS; seg++) begin
            case (seg / 3)
                0: begin
                    tx_idle_pct = 29;
                    rx_idle_pct = 47;
                end
                1: begin
                    tx_idle_pct = 47;
                    rx_idle_pct = 29;
                end
                default: begin
                    tx_idle_pct = 0;
                    rx_idle_pct = 0;
                end
            endcase
            pick_settings(seg);
            program_config();
            for (int n = 0; n < SEG_WORDS; n++) begin
                if (n == SEG_WORDS / 2)
                    drain_results();
                next_snapshot(w);
                send_snapshot(w);
            end
            drain_results();
        end

        if (fail_count == 0)
            $display("humidity_mode_controller_test: done, clean");
        else
            $display("humidity_mode_controller_test: done, errors");
        $finish;
    end

endmodule

>>> filelist.f
+incdir+src
src/hmc_pkg.sv
src/hmc_in_if.sv
src/hmc_out_if.sv
src/humidity_mode_controller.sv
verif/hmc_actuation_checker.sv
verif/humidity_mode_controller_test.sv
